FILE: rtl/ortp_pkg.sv
// Shared constants, sine table type and elaboration-time sine table builder.
package ortp_pkg;

	// Angle and trig formats.
	localparam int ANGLE_BITS     = 12;
	localparam int TRIG_FRAC_BITS = 14;
	localparam int QUARTER_BITS   = ANGLE_BITS - 2;
	localparam int QUARTER_STEPS  = 1 << QUARTER_BITS;
	localparam int ROM_ADDR_W     = QUARTER_BITS + 1;
	localparam int ROM_DATA_W     = TRIG_FRAC_BITS + 1;
	localparam int TRIG_W         = TRIG_FRAC_BITS + 2;

	// Pi/2 in unsigned Q62.
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	// Taylor series divisors (2n)(2n+1) for n = 1 .. 14.
	localparam int TAYLOR_TERMS = 14;
	localparam logic [9:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
		10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156, 10'd210,
		10'd272, 10'd342, 10'd420, 10'd506, 10'd600, 10'd702, 10'd812
	};

	// One quarter wave of sine magnitudes, entries 0 .. QUARTER_STEPS.
	typedef logic [ROM_DATA_W-1:0] sine_rom_t [QUARTER_STEPS+1];

	// Product of two Q62 values, returned in Q62.
	function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[125:62];
	endfunction

	// Sine of k quarter-wave steps, rounded half up to TRIG_FRAC_BITS fraction bits.
	function automatic logic [ROM_DATA_W-1:0] rom_sine_f(int k);
		logic [63:0] kk;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] rnd;
		kk = 64'(k);
		x = (HALF_PI_Q62 / 64'(QUARTER_STEPS)) * kk
			+ ((HALF_PI_Q62 % 64'(QUARTER_STEPS)) * kk) / 64'(QUARTER_STEPS);
		x2 = mul_q62(x, x);
		term = x;
		sum = x;
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = mul_q62(term, x2) / 64'(TAYLOR_DIV[n-1]);
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		rnd = (sum + (64'd1 << (61 - TRIG_FRAC_BITS))) >> (62 - TRIG_FRAC_BITS);
		return rnd[ROM_DATA_W-1:0];
	endfunction

	// Whole quarter-wave table, evaluated at elaboration.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int k = 0; k <= QUARTER_STEPS; k++) begin
			rom[k] = rom_sine_f(k);
		end
		return rom;
	endfunction

endpackage

FILE: rtl/oriented_rect_point_test.sv
// Throughput: one transaction per cycle; the three-stage pipeline advances
// whenever the output register is empty or being taken.
// Stages: ROM read and offset, four products, projection compare.
// Reset: arst_n clears all stage valid bits asynchronously; data is not reset.
module oriented_rect_point_test
	import ortp_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic        [COORD_BITS-1:0] rect_width,
	input  logic        [COORD_BITS-1:0] rect_height,
	input  logic        [ANGLE_BITS-1:0] turn_angle,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         inside_res
);

	localparam int OFS_W   = COORD_BITS + 1;
	localparam int PROD_W  = OFS_W + TRIG_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int BOUND_W = COORD_BITS + TRIG_FRAC_BITS - 1;

	logic en;
	logic v_s1, v_s2, v_s3;

	// Whole pipeline moves together unless the result waits.
	assign en       = !v_s3 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Quadrant folding of the angle into quarter-wave addresses.
	logic [1:0]              quad_sin, quad_cos;
	logic [QUARTER_BITS-1:0] idx;
	logic [ROM_ADDR_W-1:0]   idx_ext, idx_mirror, sin_addr, cos_addr;

	assign quad_sin   = turn_angle[ANGLE_BITS-1 -: 2];
	assign quad_cos   = quad_sin + 2'd1;
	assign idx        = turn_angle[QUARTER_BITS-1:0];
	assign idx_ext    = {1'b0, idx};
	assign idx_mirror = ROM_ADDR_W'(QUARTER_STEPS) - idx_ext;
	assign sin_addr   = quad_sin[0] ? idx_mirror : idx_ext;
	assign cos_addr   = quad_cos[0] ? idx_mirror : idx_ext;

	logic [ROM_DATA_W-1:0] sin_mag_s1, cos_mag_s1;

	ortp_sine_rom u_rom (
		.clk      (clk),
		.en       (en),
		.sin_addr (sin_addr),
		.cos_addr (cos_addr),
		.sin_mag  (sin_mag_s1),
		.cos_mag  (cos_mag_s1)
	);

	// Stage 1: offset from the centre and the quadrant signs.
	logic signed [OFS_W-1:0]      lx_s1, ly_s1;
	logic        [COORD_BITS-1:0] w_s1, h_s1;
	logic                         sin_neg_s1, cos_neg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			lx_s1      <= OFS_W'(point_x) - OFS_W'(center_x);
			ly_s1      <= OFS_W'(point_y) - OFS_W'(center_y);
			w_s1       <= rect_width;
			h_s1       <= rect_height;
			sin_neg_s1 <= quad_sin[1];
			cos_neg_s1 <= quad_cos[1];
		end
	end

	// Signed sine and cosine in Q2.TRIG_FRAC_BITS.
	logic signed [TRIG_W-1:0] sin_v, cos_v;

	assign sin_v = sin_neg_s1 ? -$signed({1'b0, sin_mag_s1}) : $signed({1'b0, sin_mag_s1});
	assign cos_v = cos_neg_s1 ? -$signed({1'b0, cos_mag_s1}) : $signed({1'b0, cos_mag_s1});

	// Stage 2: the four projection products.
	logic signed [PROD_W-1:0]     lxc_s2, lys_s2, lyc_s2, lxs_s2;
	logic        [COORD_BITS-1:0] w_s2, h_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lxc_s2 <= PROD_W'(lx_s1) * PROD_W'(cos_v);
			lys_s2 <= PROD_W'(ly_s1) * PROD_W'(sin_v);
			lyc_s2 <= PROD_W'(ly_s1) * PROD_W'(cos_v);
			lxs_s2 <= PROD_W'(lx_s1) * PROD_W'(sin_v);
			w_s2   <= w_s1;
			h_s2   <= h_s1;
		end
	end

	// Projections onto the rotated axes and the inclusive half-size tests.
	logic signed [SUM_W-1:0] dx, dy;
	logic        [SUM_W-1:0] abs_dx, abs_dy, bound_x, bound_y;
	logic                    hit;

	assign dx      = SUM_W'(lxc_s2) + SUM_W'(lys_s2);
	assign dy      = SUM_W'(lyc_s2) - SUM_W'(lxs_s2);
	assign abs_dx  = dx[SUM_W-1] ? -dx : dx;
	assign abs_dy  = dy[SUM_W-1] ? -dy : dy;
	assign bound_x = SUM_W'(BOUND_W'({w_s2, (TRIG_FRAC_BITS-1)'(0)}));
	assign bound_y = SUM_W'(BOUND_W'({h_s2, (TRIG_FRAC_BITS-1)'(0)}));
	assign hit     = (abs_dx <= bound_x) && (abs_dy <= bound_y);

	// Stage 3: result register.
	logic inside_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s3 <= hit;
		end
	end

	assign out_valid  = v_s3;
	assign inside_res = inside_s3;

endmodule

FILE: rtl/ortp_sine_rom.sv
// Quarter-wave sine ROM with two registered read ports.
module ortp_sine_rom
	import ortp_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  logic [ROM_ADDR_W-1:0] sin_addr,
	input  logic [ROM_ADDR_W-1:0] cos_addr,
	output logic [ROM_DATA_W-1:0] sin_mag,
	output logic [ROM_DATA_W-1:0] cos_mag
);

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// Both ports read on every advancing cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag <= SINE_ROM[sin_addr];
			cos_mag <= SINE_ROM[cos_addr];
		end
	end

endmodule

FILE: rtl/ortp_checker.sv
// Port-level checker for the oriented rectangle point test, with its bind.
module ortp_checker
	import ortp_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic signed [COORD_BITS-1:0] point_x,
	input logic signed [COORD_BITS-1:0] point_y,
	input logic signed [COORD_BITS-1:0] center_x,
	input logic signed [COORD_BITS-1:0] center_y,
	input logic        [COORD_BITS-1:0] rect_width,
	input logic        [COORD_BITS-1:0] rect_height,
	input logic        [ANGLE_BITS-1:0] turn_angle,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         inside_res
);

	// Transactions accepted but not yet delivered.
	logic [2:0] pending_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	// A waiting input transaction keeps its valid and payload until taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(point_x) && $stable(point_y)
			&& $stable(center_x) && $stable(center_y) && $stable(rect_width)
			&& $stable(rect_height) && $stable(turn_angle))
		else $error("input transaction changed while stalled");

	// A held result keeps its value until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(inside_res))
		else $error("result changed while stalled");

	// Input is stalled only by a result that waits.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the output stall");

	// No more transactions in flight than pipeline stages.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("too many transactions in flight");

	// A result is shown only for an accepted transaction.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result without an accepted transaction");

endmodule

bind oriented_rect_point_test ortp_checker #(.COORD_BITS(COORD_BITS)) u_ortp_checker (.*);
